>>> hw/rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and character helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SizeBitsDefault = 32;

   localparam logic [7:0] CharCr   = 8'h0D;
   localparam logic [7:0] CharLf   = 8'h0A;
   localparam logic [7:0] CharSp   = 8'h20;

   typedef enum logic [2:0] {
      PH_SIZE = 3'd0,
      PH_DATA = 3'd1,
      PH_CR   = 3'd2,
      PH_LF   = 3'd3,
      PH_STOP = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_OK   = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      status_type status;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == CharSp) || (b inside {[8'h09:8'h0D]});
   endfunction

   function automatic hex_type hex_val(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b inside {["0":"9"]}) begin
         h.value = 4'(b - 8'h30);
      end else if (b inside {["a":"f"]}) begin
         h.value = 4'(b - 8'h61 + 8'd10);
      end else if (b inside {["A":"F"]}) begin
         h.value = 4'(b - 8'h41 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      hex_val = h;
   endfunction

endpackage

>>> hw/rtl/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// A result beat is registered in the result stage when its input beat is accepted.
// Throughput: one byte per cycle while req_ready is high; the parser state updates in the accepting cycle.
// A two-entry result stage keeps input flowing while one result waits.
// Reset is synchronous and active high; the parser returns to the start of a
// size line with status in progress, and the result stage empties.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Byte-serial HTTP/1.1 chunked body decoder that passes out chunk data bytes.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
   parameter int SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_first,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status
);
   import hcbd_pkg::*;

   logic       accept;
   result_type step_result;
   result_type out_result;

   assign accept = req_valid && req_ready;

   hcbd_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .in_byte (req_in_byte),
      .first   (req_first),
      .last    (req_last),
      .result  (step_result)
   );

   hcbd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (step_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_result)
   );

   assign rsp_data_valid = out_result.data_valid;
   assign rsp_data_byte  = out_result.data_byte;
   assign rsp_status     = out_result.status;

endmodule

>>> hw/rtl/hcbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_parser
// Parser state registers and the combinational next-state logic for one byte.
// ----------------------------------------------------------------------------
module hcbd_parser #(
   parameter int SIZE_BITS = hcbd_pkg::SizeBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 first,
   input  logic                 last,
   output hcbd_pkg::result_type result
);
   import hcbd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic [SIZE_BITS-1:0] accum_ff, accum_in;
   logic                 seen_ff, seen_in;
   logic                 closed_ff, closed_in;
   logic                 crp_ff, crp_in;
   status_type           status_ff, status_in;
   logic                 data_hit;

   always_comb begin
      phase_type            ph;
      logic [SIZE_BITS-1:0] rem;
      logic [SIZE_BITS-1:0] acc;
      logic                 seen;
      logic                 closed;
      logic                 crp;
      status_type           st;
      logic                 handled;
      hex_type              h;

      ph      = phase_ff;
      rem     = remaining_ff;
      acc     = accum_ff;
      seen    = seen_ff;
      closed  = closed_ff;
      crp     = crp_ff;
      st      = status_ff;
      handled = 1'b0;
      h       = hex_val(in_byte);
      data_hit = 1'b0;

      if (first) begin
         ph     = PH_SIZE;
         rem    = '0;
         acc    = '0;
         seen   = 1'b0;
         closed = 1'b0;
         crp    = 1'b0;
         st     = ST_BUSY;
      end

      if (st == ST_BUSY) begin
         case (ph)
            PH_SIZE: begin
               if (crp) begin
                  crp = 1'b0;
                  if (in_byte == CharLf) begin
                     handled = 1'b1;
                     if (!seen) begin
                        st = ST_ERR;
                        ph = PH_STOP;
                     end else if (acc == '0) begin
                        st = ST_OK;
                        ph = PH_STOP;
                     end else begin
                        rem    = acc;
                        ph     = PH_DATA;
                        acc    = '0;
                        seen   = 1'b0;
                        closed = 1'b0;
                     end
                  end else if (seen) begin
                     closed = 1'b1;
                  end
               end
               if (!handled) begin
                  if (in_byte == CharCr) begin
                     crp = 1'b1;
                  end else if (!seen) begin
                     if (!is_ws(in_byte)) begin
                        if (!h.valid) begin
                           st = ST_ERR;
                           ph = PH_STOP;
                        end else begin
                           seen = 1'b1;
                           acc  = {{(SIZE_BITS-4){1'b0}}, h.value};
                        end
                     end
                  end else if (!closed) begin
                     if (!h.valid) begin
                        closed = 1'b1;
                     end else if (|acc[SIZE_BITS-1:SIZE_BITS-4]) begin
                        st = ST_ERR;
                        ph = PH_STOP;
                     end else begin
                        acc = {acc[SIZE_BITS-5:0], h.value};
                     end
                  end
               end
            end
            PH_DATA: begin
               data_hit = 1'b1;
               rem      = rem - SIZE_BITS'(1);
               if (rem == '0) begin
                  ph = PH_CR;
               end
            end
            PH_CR: begin
               if (in_byte == CharCr) begin
                  ph = PH_LF;
               end else begin
                  st = ST_ERR;
                  ph = PH_STOP;
               end
            end
            PH_LF: begin
               if (in_byte == CharLf) begin
                  ph     = PH_SIZE;
                  acc    = '0;
                  seen   = 1'b0;
                  closed = 1'b0;
                  crp    = 1'b0;
               end else begin
                  st = ST_ERR;
                  ph = PH_STOP;
               end
            end
            default: begin
               st = ST_ERR;
               ph = PH_STOP;
            end
         endcase
         if (last && st == ST_BUSY) begin
            st = ST_ERR;
            ph = PH_STOP;
         end
      end

      phase_in     = ph;
      remaining_in = rem;
      accum_in     = acc;
      seen_in      = seen;
      closed_in    = closed;
      crp_in       = crp;
      status_in    = st;
   end

   always_comb begin
      result.data_valid = data_hit;
      result.data_byte  = data_hit ? in_byte : 8'd0;
      result.status     = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         remaining_ff <= '0;
         accum_ff     <= '0;
         seen_ff      <= 1'b0;
         closed_ff    <= 1'b0;
         crp_ff       <= 1'b0;
         status_ff    <= ST_BUSY;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         accum_ff     <= accum_in;
         seen_ff      <= seen_in;
         closed_ff    <= closed_in;
         crp_ff       <= crp_in;
         status_ff    <= status_in;
      end
   end

endmodule

>>> hw/rtl/hcbd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register with a skid stage, so a beat is taken every cycle while the skid stage is empty.
// ----------------------------------------------------------------------------
module hcbd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hcbd_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hcbd_pkg::result_type out_data
);
   import hcbd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
